// File: rtl/core/awsp_pkg.sv
// Shared constants, types and table helpers for the ADC window statistics block.
`timescale 1ns / 1ps
package awsp_pkg;

    localparam int MAX_WINDOW_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TRIG_DEPTH_DEF  = 1024;

    localparam int CFG_W       = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd400;

    localparam int CORDIC_STEPS = 30;
    localparam longint CORDIC_GAIN = 64'sd652032874;

    // Arctangent of 2^-i in units of 2pi/2^32.
    localparam logic [31:0] ATAN_UNITS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef logic [1:0] t_div_op;
    localparam t_div_op DIV_IDX  = 2'd0;
    localparam t_div_op DIV_MOD  = 2'd1;
    localparam t_div_op DIV_MEAN = 2'd2;
    localparam t_div_op DIV_VAR  = 2'd3;

    typedef struct packed {
        logic    load;
        logic    div_start;
        t_div_op div_op;
        logic    take_sin;
        logic    take_cos;
        logic    mul;
        logic    acc;
        logic    mul_sq;
        logic    mul_num;
        logic    mean_take;
        logic    sqrt_start;
        logic    cord_load;
        logic    norm_step;
        logic    cord_flip;
        logic    cord_step;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic last;
        logic zero_vec;
        logic norm_done;
        logic cord_last;
        logic out_valid;
    } t_stat;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // One quarter-wave sine entry in Q1.15 from a rotation CORDIC; z is the angle
    // in units of 2pi/2^32.
    function automatic logic [16:0] f_quarter_entry(input longint z_in);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint r;
        x = CORDIC_GAIN;
        y = 0;
        z = z_in;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                x = x - dy;
                y = y + dx;
                z = z - longint'({32'd0, ATAN_UNITS[i]});
            end else begin
                x = x + dy;
                y = y - dx;
                z = z + longint'({32'd0, ATAN_UNITS[i]});
            end
        end
        r = (y + (longint'(1) <<< 14)) >>> 15;
        if (r < 0) begin
            r = 0;
        end
        if (r > 32768) begin
            r = 32768;
        end
        return r[16:0];
    endfunction

endpackage

// File: rtl/core/awsp_ctrl.sv
// Sequencer for per-word accumulation and the end-of-window result computation.
`timescale 1ns / 1ps
module awsp_ctrl
    import awsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_stall
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PDIV  = 4'd1;
    localparam logic [3:0] ST_PMOD  = 4'd2;
    localparam logic [3:0] ST_SIN   = 4'd3;
    localparam logic [3:0] ST_COS   = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_ACC   = 4'd6;
    localparam logic [3:0] ST_MEAN  = 4'd7;
    localparam logic [3:0] ST_NUM   = 4'd8;
    localparam logic [3:0] ST_WMEAN = 4'd9;
    localparam logic [3:0] ST_VAR   = 4'd10;
    localparam logic [3:0] ST_WVAR  = 4'd11;
    localparam logic [3:0] ST_SQRT  = 4'd12;
    localparam logic [3:0] ST_NORM  = 4'd13;
    localparam logic [3:0] ST_ROT   = 4'd14;
    localparam logic [3:0] ST_LOAD  = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_MOD;
                    n_state         = ST_PMOD;
                end
            end
            ST_PMOD: begin
                if (i_stat.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = DIV_IDX;
                    n_state         = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_SIN;
                end
            end
            ST_SIN: begin
                o_cmd.take_sin = 1'b1;
                n_state        = ST_COS;
            end
            ST_COS: begin
                o_cmd.take_cos = 1'b1;
                n_state        = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.last ? ST_MEAN : ST_IDLE;
            end
            ST_MEAN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_MEAN;
                o_cmd.mul_sq    = 1'b1;
                n_state         = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.mul_num = 1'b1;
                n_state       = ST_WMEAN;
            end
            ST_WMEAN: begin
                if (i_stat.div_done) begin
                    o_cmd.mean_take = 1'b1;
                    n_state         = ST_VAR;
                end
            end
            ST_VAR: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_VAR;
                n_state         = ST_WVAR;
            end
            ST_WVAR: begin
                if (i_stat.div_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.cord_load = 1'b1;
                    n_state         = ST_NORM;
                end
            end
            ST_NORM: begin
                if (i_stat.zero_vec) begin
                    n_state = ST_LOAD;
                end else if (i_stat.norm_done) begin
                    o_cmd.cord_flip = 1'b1;
                    n_state         = ST_ROT;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            ST_ROT: begin
                o_cmd.cord_step = 1'b1;
                if (i_stat.cord_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!i_stat.out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

// File: rtl/core/awsp_dp.sv
// Datapath: window accumulators, shared divider, square root, CORDIC and output register.
`timescale 1ns / 1ps
module awsp_dp
    import awsp_pkg::*;
#(
    parameter int MAX_WINDOW       = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [SAMPLE_BITS-1:0]        o_minimum,
    output logic [SAMPLE_BITS-1:0]        o_maximum,
    output logic [SAMPLE_BITS-1:0]        o_peak_to_peak,
    output logic [SAMPLE_BITS+7:0]        o_mean_level,
    output logic [SAMPLE_BITS+6:0]        o_std_deviation,
    output logic signed [15:0]            o_phase_angle
);

    localparam int SB    = SAMPLE_BITS;
    localparam int IW    = $clog2(MAX_WINDOW);
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int TW    = $clog2(TRIG_TABLE_DEPTH);
    localparam int DPW   = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int QD    = TRIG_TABLE_DEPTH / 4;
    localparam int QIW   = $clog2(QD + 1);
    localparam int SUMW  = SB + IW;
    localparam int SQW   = 2 * SB + IW;
    localparam int PRW   = SB + 17;
    localparam int ACCW  = PRW + IW;
    localparam int PDW   = IW + TW;
    localparam int MNW   = SUMW + 8;
    localparam int DW    = NW + SQW;
    localparam int VW    = DW + 16;
    localparam int DVW   = f_max(VW, f_max(PDW, MNW));
    localparam int DSW   = f_max(2 * NW, DPW);
    localparam int CNTW  = $clog2(DVW + 1);
    localparam int RW    = (DVW + 1) / 2;
    localparam int SCW   = $clog2(RW + 1);
    localparam int CW    = f_max(ACCW + 1, 42) + 2;
    localparam int MEANW = SB + 8;
    localparam int STDW  = SB + 7;
    localparam int MW    = f_max(CFG_W, NW + 1);
    localparam int SATW  = f_max(RW, STDW);

    localparam logic signed [CW-1:0] NORM_LIM = CW'(longint'(1) <<< 40);

    typedef logic [16:0] t_qtab [0:QD];

    function automatic t_qtab f_build_qtab();
        t_qtab t;
        for (int k = 0; k <= QD; k++) begin
            t[k] = f_quarter_entry(longint'((64'(k) << 32) / 64'(TRIG_TABLE_DEPTH)));
        end
        return t;
    endfunction

    localparam t_qtab QTAB = f_build_qtab();

    // Configuration and window state.
    logic [CFG_W-1:0]       r_cfg;
    logic [IW-1:0]          r_idx;
    logic [SB-1:0]          r_min;
    logic [SB-1:0]          r_max;
    logic [SUMW-1:0]        r_sum;
    logic [SQW-1:0]         r_sqsum;
    logic signed [ACCW-1:0] r_cacc;
    logic signed [ACCW-1:0] r_sacc;

    // Per-word pipeline.
    logic [SB-1:0]          r_sample;
    logic signed [16:0]     r_sin;
    logic signed [16:0]     r_cos;
    logic signed [PRW-1:0]  r_pc;
    logic signed [PRW-1:0]  r_ps;
    logic [2*SB-1:0]        r_sq;

    // Shared divider.
    logic [DVW-1:0]         r_dq;
    logic [DSW-1:0]         r_drem;
    logic [DSW-1:0]         r_ddiv;
    logic [CNTW-1:0]        r_dcnt;

    // End-of-window terms.
    logic [MEANW-1:0]       r_mean;
    logic [2*SUMW-1:0]      r_pa;
    logic [DW-1:0]          r_pb;

    // Square root.
    logic [2*RW-1:0]        r_sop;
    logic [RW-1:0]          r_root;
    logic [RW+1:0]          r_srem;
    logic [SCW-1:0]         r_scnt;

    // Phase CORDIC.
    logic signed [CW-1:0]   r_cx;
    logic signed [CW-1:0]   r_cy;
    logic [31:0]            r_cz;
    logic [4:0]             r_ci;

    // Output word.
    logic                   r_o_valid;
    logic [SB-1:0]          r_o_min;
    logic [SB-1:0]          r_o_max;
    logic [SB-1:0]          r_o_p2p;
    logic [MEANW-1:0]       r_o_mean;
    logic [STDW-1:0]        r_o_std;
    logic [15:0]            r_o_phase;

    logic [MW-1:0]          cfg_x;
    logic [NW-1:0]          n_len;
    logic [2*NW-1:0]        nn;
    logic [PDW-1:0]         idx_scaled;
    logic [DW-1:0]          var_num;
    logic [DVW-1:0]         div_val;
    logic [DSW-1:0]         div_den;
    logic [CNTW-1:0]        div_bits;
    logic [DSW:0]           div_trial;
    logic                   div_ge;
    logic [TW:0]            p_sel;
    logic [TW:0]            p_rel;
    logic                   p_neg;
    logic [16:0]            q_ent;
    logic signed [16:0]     trig;
    logic signed [SB:0]     s_ext;
    logic signed [SB+17:0]  prod_c;
    logic signed [SB+17:0]  prod_s;
    logic [RW+3:0]          sq_sh;
    logic [RW+3:0]          sq_trial;
    logic                   sq_ge;
    logic signed [CW-1:0]   c_dx;
    logic signed [CW-1:0]   c_dy;
    logic [31:0]            ph_round;
    logic [STDW-1:0]        std_sat;
    logic                   out_take;

    assign cfg_x = MW'(r_cfg);

    always_comb begin
        if (cfg_x == '0) begin
            n_len = NW'(1);
        end else if (cfg_x > MW'(MAX_WINDOW)) begin
            n_len = NW'(MAX_WINDOW);
        end else begin
            n_len = cfg_x[NW-1:0];
        end
    end

    // The position is first reduced modulo the window length, so the scaled quotient
    // lands inside the table without a wrap by the table depth.
    assign nn         = {{NW{1'b0}}, n_len} * {{NW{1'b0}}, n_len};
    assign idx_scaled = PDW'(r_drem[IW-1:0]) * PDW'(TRIG_TABLE_DEPTH);
    assign var_num    = (r_pb > DW'(r_pa)) ? (r_pb - DW'(r_pa)) : '0;

    always_comb begin
        case (i_cmd.div_op)
            DIV_IDX: begin
                div_val  = DVW'(idx_scaled) << (DVW - PDW);
                div_den  = DSW'(n_len);
                div_bits = CNTW'(PDW);
            end
            DIV_MOD: begin
                div_val  = DVW'(r_idx) << (DVW - IW);
                div_den  = DSW'(n_len);
                div_bits = CNTW'(IW);
            end
            DIV_MEAN: begin
                div_val  = DVW'({r_sum, 8'd0}) << (DVW - MNW);
                div_den  = DSW'(n_len);
                div_bits = CNTW'(MNW);
            end
            default: begin
                div_val  = DVW'({var_num, 16'd0}) << (DVW - VW);
                div_den  = DSW'(nn);
                div_bits = CNTW'(VW);
            end
        endcase
    end

    assign div_trial = {r_drem, r_dq[DVW-1]};
    assign div_ge    = (div_trial >= {1'b0, r_ddiv});

    // Sine table lookup by quadrant symmetry; the cosine reads a quarter turn ahead.
    always_comb begin
        p_sel = {1'b0, r_dq[TW-1:0]};
        if (i_cmd.take_cos) begin
            p_sel = p_sel + (TW+1)'(QD);
            if (p_sel >= (TW+1)'(TRIG_TABLE_DEPTH)) begin
                p_sel = p_sel - (TW+1)'(TRIG_TABLE_DEPTH);
            end
        end
        if (p_sel < (TW+1)'(QD)) begin
            p_rel = p_sel;
            p_neg = 1'b0;
        end else if (p_sel < (TW+1)'(2 * QD)) begin
            p_rel = (TW+1)'(2 * QD) - p_sel;
            p_neg = 1'b0;
        end else if (p_sel < (TW+1)'(3 * QD)) begin
            p_rel = p_sel - (TW+1)'(2 * QD);
            p_neg = 1'b1;
        end else begin
            p_rel = (TW+1)'(TRIG_TABLE_DEPTH) - p_sel;
            p_neg = 1'b1;
        end
        q_ent = QTAB[p_rel[QIW-1:0]];
        trig  = p_neg ? -$signed(q_ent) : $signed(q_ent);
    end

    assign s_ext  = $signed({1'b0, r_sample});
    assign prod_c = s_ext * r_cos;
    assign prod_s = s_ext * r_sin;

    assign sq_sh    = {r_srem, r_sop[2*RW-1 -: 2]};
    assign sq_trial = (RW+4)'({r_root, 2'b01});
    assign sq_ge    = (sq_sh >= sq_trial);

    assign c_dx = r_cx >>> r_ci;
    assign c_dy = r_cy >>> r_ci;

    assign ph_round = r_cz + 32'h0000_8000;
    assign std_sat  = (SATW'(r_root) > SATW'({STDW{1'b1}})) ? {STDW{1'b1}} : STDW'(r_root);
    assign out_take = r_o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_idx   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_sum   <= '0;
            r_sqsum <= '0;
            r_cacc  <= '0;
            r_sacc  <= '0;
        end else if (i_cmd.acc) begin
            if (r_sample < r_min) begin
                r_min <= r_sample;
            end
            if (r_sample > r_max) begin
                r_max <= r_sample;
            end
            r_sum   <= r_sum + SUMW'(r_sample);
            r_sqsum <= r_sqsum + SQW'(r_sq);
            r_cacc  <= r_cacc + {{(ACCW-PRW){r_pc[PRW-1]}}, r_pc};
            r_sacc  <= r_sacc + {{(ACCW-PRW){r_ps[PRW-1]}}, r_ps};
            if (!o_stat.last) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.take_sin) begin
            r_sin <= trig;
        end
        if (i_cmd.take_cos) begin
            r_cos <= trig;
        end
        if (i_cmd.mul) begin
            r_pc <= prod_c[PRW-1:0];
            r_ps <= prod_s[PRW-1:0];
            r_sq <= r_sample * r_sample;
        end
        if (i_cmd.mul_sq) begin
            r_pa <= r_sum * r_sum;
        end
        if (i_cmd.mul_num) begin
            r_pb <= DW'(n_len) * DW'(r_sqsum);
        end
        if (i_cmd.mean_take) begin
            r_mean <= r_dq[MEANW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dq   <= div_val;
            r_drem <= '0;
            r_ddiv <= div_den;
            r_dcnt <= div_bits;
        end else if (r_dcnt != '0) begin
            r_drem <= div_ge ? DSW'(div_trial - {1'b0, r_ddiv}) : DSW'(div_trial);
            r_dq   <= {r_dq[DVW-2:0], div_ge};
            r_dcnt <= r_dcnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt <= '0;
        end else if (i_cmd.sqrt_start) begin
            r_sop  <= (2*RW)'(r_dq);
            r_root <= '0;
            r_srem <= '0;
            r_scnt <= SCW'(RW);
        end else if (r_scnt != '0) begin
            r_srem <= sq_ge ? (RW+2)'(sq_sh - sq_trial) : (RW+2)'(sq_sh);
            r_root <= {r_root[RW-2:0], sq_ge};
            r_sop  <= {r_sop[2*RW-3:0], 2'b00};
            r_scnt <= r_scnt - SCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cord_load) begin
            r_cx <= CW'(r_cacc);
            r_cy <= -CW'(r_sacc);
            r_cz <= '0;
        end else if (i_cmd.norm_step) begin
            r_cx <= r_cx <<< 1;
            r_cy <= r_cy <<< 1;
        end else if (i_cmd.cord_flip) begin
            r_ci <= '0;
            if (r_cx < 0) begin
                r_cx <= -r_cx;
                r_cy <= -r_cy;
                r_cz <= 32'h8000_0000;
            end
        end else if (i_cmd.cord_step) begin
            r_ci <= r_ci + 5'd1;
            if (r_cy > 0) begin
                r_cx <= r_cx + c_dy;
                r_cy <= r_cy - c_dx;
                r_cz <= r_cz + ATAN_UNITS[r_ci];
            end else begin
                r_cx <= r_cx - c_dy;
                r_cy <= r_cy + c_dx;
                r_cz <= r_cz - ATAN_UNITS[r_ci];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (out_take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_min   <= r_min;
            r_o_max   <= r_max;
            r_o_p2p   <= r_max - r_min;
            r_o_mean  <= r_mean;
            r_o_std   <= std_sat;
            r_o_phase <= ph_round[31:16];
        end
    end

    assign o_stat.div_done  = (r_dcnt == '0);
    assign o_stat.sqrt_done = (r_scnt == '0);
    assign o_stat.last      = ((NW+1)'(r_idx) + (NW+1)'(1)) >= (NW+1)'(n_len);
    assign o_stat.zero_vec  = (r_cx == '0) && (r_cy == '0);
    assign o_stat.norm_done = !((r_cx < NORM_LIM) && (r_cx > -NORM_LIM) &&
                                (r_cy < NORM_LIM) && (r_cy > -NORM_LIM));
    assign o_stat.cord_last = (r_ci == 5'(CORDIC_STEPS - 1));
    assign o_stat.out_valid = r_o_valid;

    assign o_valid         = r_o_valid;
    assign o_minimum       = r_o_min;
    assign o_maximum       = r_o_max;
    assign o_peak_to_peak  = r_o_p2p;
    assign o_mean_level    = r_o_mean;
    assign o_std_deviation = r_o_std;
    assign o_phase_angle   = $signed(r_o_phase);

endmodule

// File: rtl/core/adc_window_stats_and_phase.sv
// Top level of the ADC window statistics and fundamental phase block.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_sample
//   output   out        o_valid / i_stall   o_minimum .. o_phase_angle
//   config   in         i_cfg_we            i_cfg_data (window length)
//
// Each input word is handled by the bit-serial divider, which reduces the word position modulo
// the window length and then divides the scaled position by that length to form the table
// index; o_stall stays high until the word is accumulated.
// The last word of a window also runs the mean and variance divisions, the square root and
// up to 40 normalizing shifts plus 30 CORDIC steps of the phase.
// Reset is synchronous and active low; it restores a window length of 400 and clears the window.
// A stalled result holds in the output register while the next window is collected.
`timescale 1ns / 1ps
module adc_window_stats_and_phase
    import awsp_pkg::*;
#(
    parameter int MAX_WINDOW       = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SAMPLE_BITS-1:0] o_minimum,
    output logic [SAMPLE_BITS-1:0] o_maximum,
    output logic [SAMPLE_BITS-1:0] o_peak_to_peak,
    output logic [SAMPLE_BITS+7:0] o_mean_level,
    output logic [SAMPLE_BITS+6:0] o_std_deviation,
    output logic signed [15:0]     o_phase_angle
);

    t_cmd  cmd;
    t_stat stat;

    awsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    awsp_dp #(
        .MAX_WINDOW       (MAX_WINDOW),
        .SAMPLE_BITS      (SAMPLE_BITS),
        .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_sample),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_minimum       (o_minimum),
        .o_maximum       (o_maximum),
        .o_peak_to_peak  (o_peak_to_peak),
        .o_mean_level    (o_mean_level),
        .o_std_deviation (o_std_deviation),
        .o_phase_angle   (o_phase_angle)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted twice in a row");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_valid)
        else $error("result load did not raise valid");

    a_p2p_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_peak_to_peak == o_maximum - o_minimum) && (o_minimum <= o_maximum))
        else $error("peak-to-peak inconsistent with minimum and maximum");
`endif

endmodule

// File: bench/adc_window_stats_and_phase_tb.sv
// Self-checking testbench for the ADC window statistics and phase block.
`timescale 1ns / 1ps
module adc_window_stats_and_phase_tb;
    import awsp_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int TABLE_DEPTH   = 1024;
    localparam int QUARTER       = TABLE_DEPTH / 4;
    localparam int WINDOW_CAP    = 1024;

    typedef struct packed {
        logic [11:0]        minimum;
        logic [11:0]        maximum;
        logic [11:0]        peak_to_peak;
        logic [19:0]        mean_level;
        logic [18:0]        std_deviation;
        logic signed [15:0] phase_angle;
    } window_result_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [11:0]        i_sample;
    logic               o_valid;
    logic               i_stall;
    logic [11:0]        o_minimum;
    logic [11:0]        o_maximum;
    logic [11:0]        o_peak_to_peak;
    logic [19:0]        o_mean_level;
    logic [18:0]        o_std_deviation;
    logic signed [15:0] o_phase_angle;

    logic [11:0]    sample_q[$];
    window_result_t window_q[$];
    int             mismatches;
    int             idle_left;
    int             stall_left;
    bit             calm;
    int             cycles;

    // Predictor copy of the window state and the window length register.
    logic [10:0]    window_len;
    int unsigned    win_index;
    longint         win_min;
    longint         win_max;
    longint         win_sum;
    longint         win_sq_sum;
    longint         cos_acc;
    longint         sin_acc;
    longint         sine_rom[QUARTER+1];

    adc_window_stats_and_phase u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_minimum      (o_minimum),
        .o_maximum      (o_maximum),
        .o_peak_to_peak (o_peak_to_peak),
        .o_mean_level   (o_mean_level),
        .o_std_deviation(o_std_deviation),
        .o_phase_angle  (o_phase_angle)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint rotate_sine(input int k);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint r;
        x = CORDIC_GAIN;
        y = 0;
        z = longint'(k) <<< 22;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                x = x - dy;
                y = y + dx;
                z = z - longint'(ATAN_UNITS[i]);
            end else begin
                x = x + dy;
                y = y - dx;
                z = z + longint'(ATAN_UNITS[i]);
            end
        end
        r = (y + 16384) >>> 15;
        if (r < 0) r = 0;
        if (r > 32768) r = 32768;
        return r;
    endfunction

    function automatic longint wave_sine(input longint unsigned p);
        int q;
        int r;
        p = p % TABLE_DEPTH;
        q = int'(p / QUARTER);
        r = int'(p % QUARTER);
        case (q)
            0: return sine_rom[r];
            1: return sine_rom[QUARTER - r];
            2: return -sine_rom[r];
            default: return -sine_rom[QUARTER - r];
        endcase
    endfunction

    function automatic logic [15:0] bin_phase(input longint re, input longint im);
        longint x;
        longint y;
        longint dx;
        longint dy;
        logic [31:0] z;
        x = re;
        y = -im;
        z = 32'd0;
        if (x == 0 && y == 0) return 16'd0;
        while ((x < 0 ? -x : x) < (longint'(1) <<< 40) &&
               (y < 0 ? -y : y) < (longint'(1) <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0) begin
                x = x + dy;
                y = y - dx;
                z = z + ATAN_UNITS[i];
            end else begin
                x = x - dy;
                y = y + dx;
                z = z - ATAN_UNITS[i];
            end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void clear_window();
        win_index = 0;
        win_min = 4095;
        win_max = 0;
        win_sum = 0;
        win_sq_sum = 0;
        cos_acc = 0;
        sin_acc = 0;
    endfunction

    function automatic void accumulate_sample(input logic [11:0] s);
        longint unsigned n;
        longint unsigned p;
        longint unsigned sq;
        longint unsigned num;
        longint unsigned d;
        longint unsigned stdv;
        longint sv;
        window_result_t res;
        n = window_len;
        if (n == 0) n = 1;
        if (n > WINDOW_CAP) n = WINDOW_CAP;
        sv = longint'(s);
        if (sv < win_min) win_min = sv;
        if (sv > win_max) win_max = sv;
        win_sum = win_sum + sv;
        win_sq_sum = win_sq_sum + sv * sv;
        p = (longint'(win_index) * TABLE_DEPTH) / n;
        cos_acc = cos_acc + sv * wave_sine(p + QUARTER);
        sin_acc = sin_acc + sv * wave_sine(p);
        if (win_index + 1 < n) begin
            win_index = (win_index + 1) & 32'h3FF;
            return;
        end
        sq = win_sum * win_sum;
        num = n * win_sq_sum;
        d = (num > sq) ? num - sq : 0;
        stdv = int_sqrt((d * 65536) / (n * n));
        if (stdv > 64'h7FFFF) stdv = 64'h7FFFF;
        res.minimum = win_min[11:0];
        res.maximum = win_max[11:0];
        res.peak_to_peak = 12'(win_max - win_min);
        res.mean_level = 20'((longint'(win_sum) * 256) / n);
        res.std_deviation = stdv[18:0];
        res.phase_angle = bin_phase(cos_acc, sin_acc);
        window_q.push_back(res);
        clear_window();
    endfunction

    // Sender: drives the next pending word once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            idle_left <= 0;
        end else if (!i_valid || !o_stall) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                idle_left <= $urandom_range(0, 16);
                i_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                i_sample <= sample_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 16);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: predicts on accepted input words and checks accepted results.
    always @(posedge i_clk) begin
        window_result_t exp_res;
        window_result_t got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                accumulate_sample(i_sample);
            end
            if (o_valid && !i_stall) begin
                got = '{o_minimum, o_maximum, o_peak_to_peak, o_mean_level,
                        o_std_deviation, o_phase_angle};
                if (window_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("Unexpected result word: %p", got);
                    end
                end else begin
                    exp_res = window_q.pop_front();
                    if (got !== exp_res) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $display("Result mismatch: expected %p, actual %p", exp_res, got);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [11:0] random_sample(input int style, input logic [11:0] centre);
        case (style)
            0: return 12'($urandom);
            1: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            2: return centre + 12'($urandom_range(0, 63)) - 12'd32;
            default: return centre;
        endcase
    endfunction

    task automatic settle();
        while (sample_q.size() > 0 || i_valid) @(posedge i_clk);
        while (window_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [10:0] len);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= len;
        window_len = len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_windows(input int words);
        int style;
        logic [11:0] centre;
        style = $urandom_range(0, 3);
        centre = 12'($urandom);
        for (int k = 0; k < words; k++) begin
            if ($urandom_range(0, 15) == 0) style = $urandom_range(0, 3);
            sample_q.push_back(random_sample(style, centre));
        end
    endtask

    initial begin
        int len;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_sample = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        mismatches = 0;
        cycles = 0;
        calm = 1'b0;
        window_len = CFG_RESET;
        for (int k = 0; k <= QUARTER; k++) sine_rom[k] = rotate_sine(k);
        clear_window();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Window length from reset.
        send_windows(400);

        // Single-word windows with the extreme samples, then length zero.
        set_length(11'd1);
        sample_q.push_back(12'd0);
        sample_q.push_back(12'd4095);
        sample_q.push_back(12'hAAA);
        sample_q.push_back(12'h555);
        set_length(11'd0);
        sample_q.push_back(12'd4095);
        sample_q.push_back(12'd1);
        set_length(11'd2);
        sample_q.push_back(12'd0);
        sample_q.push_back(12'd4095);
        sample_q.push_back(12'd4095);
        sample_q.push_back(12'd0);
        // Constant window: zero spectrum apart from the DC bin, no variance.
        set_length(11'd4);
        repeat (4) sample_q.push_back(12'd2048);
        repeat (4) sample_q.push_back(12'd0);
        // Length shortened part way through a window.
        set_length(11'd8);
        repeat (5) sample_q.push_back(12'($urandom));
        set_length(11'd3);
        sample_q.push_back(12'd4095);
        set_length(11'd7);
        sample_q.push_back(12'd1234);
        set_length(11'd2);
        sample_q.push_back(12'd10);

        // Random short lengths.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 6) calm = 1'b1;
            len = $urandom_range(1, 16);
            set_length(11'(len));
            send_windows(len * $urandom_range(1, 2) + $urandom_range(0, 1) * (len - 1));
        end
        set_length(11'd5);
        send_windows(10);

        settle();
        if (mismatches == 0 && window_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
